FILE: design/xrrg_pkg.sv
// Shared types and constants for the xorshift ring random generator.
package xrrg_pkg;

	localparam int WORD_W = 64;
	localparam int RING_DEPTH = 64;
	localparam int POS_W = $clog2(RING_DEPTH);
	localparam int OUT_BITS_W = 7;
	localparam int HALF_W = WORD_W / 2;

	localparam logic [POS_W-1:0] LAG_AHEAD = POS_W'(11);
	localparam logic [POS_W-1:0] POS_STEP = POS_W'(1);
	localparam logic [POS_W-1:0] LAST_SLOT = POS_W'(RING_DEPTH - 1);

	localparam logic [WORD_W-1:0] SEED_MULT = 64'h5851_F42D_4C95_7F2D;
	localparam logic [HALF_W-1:0] SEED_MULT_LO = SEED_MULT[HALF_W-1:0];
	localparam logic [HALF_W-1:0] SEED_MULT_HI = SEED_MULT[WORD_W-1:HALF_W];

	localparam logic [OUT_BITS_W-1:0] OUT_BITS_RESET = 7'd64;

	// request codes
	localparam logic REQ_GENERATE = 1'b0;
	localparam logic REQ_SEED = 1'b1;

	// configuration register map
	localparam int PADDR_W = 3;
	localparam logic REG_OUT_BITS = 1'b0;

	typedef struct packed {
		logic we;
		logic [POS_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} ring_wr_t;

endpackage

FILE: design/xrrg_ring_mem.sv
// Ring word memory: one write port, two registered read ports.
module xrrg_ring_mem (
	input  logic clk,
	input  xrrg_pkg::ring_wr_t wr,
	input  logic re,
	input  logic [xrrg_pkg::POS_W-1:0] raddr_a,
	input  logic [xrrg_pkg::POS_W-1:0] raddr_b,
	output logic [xrrg_pkg::WORD_W-1:0] rdata_a,
	output logic [xrrg_pkg::WORD_W-1:0] rdata_b
);

	logic [xrrg_pkg::WORD_W-1:0] mem [xrrg_pkg::RING_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: design/xrrg_mix.sv
// Xorshift mixing of two ring words, bit reversal and top-bit masking.
module xrrg_mix (
	input  logic [xrrg_pkg::WORD_W-1:0] t_word,
	input  logic [xrrg_pkg::WORD_W-1:0] v_word,
	input  logic [xrrg_pkg::OUT_BITS_W-1:0] out_bits,
	output logic [xrrg_pkg::WORD_W-1:0] new_word,
	output logic [xrrg_pkg::WORD_W-1:0] result
);

	logic [xrrg_pkg::WORD_W-1:0] t1, t2, v1, v2, rev, mask;

	always_comb begin
		t1 = t_word ^ (t_word << 33);
		t2 = t1 ^ (t1 >> 26);
		v1 = v_word ^ (v_word << 27);
		v2 = v1 ^ (v1 >> 29);
		new_word = v2 ^ t2;
	end

	// keep bit i when i + out_bits reaches the word width
	always_comb begin
		for (int i = 0; i < xrrg_pkg::WORD_W; i++) begin
			rev[i] = new_word[xrrg_pkg::WORD_W-1-i];
			mask[i] = ({1'b0, out_bits} + 8'(i)) >= 8'(xrrg_pkg::WORD_W);
		end
		result = rev & mask;
	end

endmodule

FILE: design/xrrg_seed_unit.sv
// Seed sequencer: fills the ring with one shared 32x32 multiplier.
module xrrg_seed_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [xrrg_pkg::WORD_W-1:0] seed_value,
	output xrrg_pkg::ring_wr_t wr,
	output logic done
);

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_WRITE = 6'b000010,
		PH_MUL0  = 6'b000100,
		PH_MUL1  = 6'b001000,
		PH_MUL2  = 6'b010000,
		PH_MUL3  = 6'b100000
	} seed_phase_t;

	seed_phase_t phase_q, phase_d;
	logic [xrrg_pkg::POS_W-1:0] idx_q;
	logic [xrrg_pkg::WORD_W-1:0] prev_q, acc_q, prod_q, seed_q, mix;
	logic [xrrg_pkg::HALF_W-1:0] op_a, op_b;

	assign mix = prev_q ^ {62'd0, prev_q[63:62]};

	always_comb begin
		op_a = '0;
		op_b = '0;
		phase_d = phase_q;
		unique case (phase_q)
			PH_IDLE: begin
				if (start) phase_d = PH_WRITE;
			end
			PH_WRITE: begin
				phase_d = (idx_q == xrrg_pkg::LAST_SLOT) ? PH_IDLE : PH_MUL0;
			end
			PH_MUL0: begin
				op_a = mix[xrrg_pkg::HALF_W-1:0];
				op_b = xrrg_pkg::SEED_MULT_LO;
				phase_d = PH_MUL1;
			end
			PH_MUL1: begin
				op_a = mix[xrrg_pkg::HALF_W-1:0];
				op_b = xrrg_pkg::SEED_MULT_HI;
				phase_d = PH_MUL2;
			end
			PH_MUL2: begin
				op_a = mix[xrrg_pkg::WORD_W-1:xrrg_pkg::HALF_W];
				op_b = xrrg_pkg::SEED_MULT_LO;
				phase_d = PH_MUL3;
			end
			PH_MUL3: begin
				phase_d = PH_WRITE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q <= '0;
		end else begin
			phase_q <= phase_d;
			if (phase_q == PH_IDLE && start) begin
				idx_q <= '0;
			end else if (phase_q == PH_WRITE) begin
				idx_q <= idx_q + xrrg_pkg::POS_STEP;
			end
		end
	end

	// low product plus seed, then the two cross products shifted up
	always_ff @(posedge clk) begin
		prod_q <= xrrg_pkg::WORD_W'(op_a) * xrrg_pkg::WORD_W'(op_b);
		if (phase_q == PH_IDLE && start) begin
			seed_q <= seed_value;
			acc_q <= seed_value;
		end else if (phase_q == PH_MUL1) begin
			acc_q <= prod_q + seed_q;
		end else if (phase_q == PH_MUL2 || phase_q == PH_MUL3) begin
			acc_q <= acc_q + {prod_q[xrrg_pkg::HALF_W-1:0], {xrrg_pkg::HALF_W{1'b0}}};
		end
		if (phase_q == PH_WRITE) begin
			prev_q <= acc_q;
		end
	end

	assign wr.we = (phase_q == PH_WRITE);
	assign wr.addr = idx_q;
	assign wr.data = acc_q;
	assign done = (phase_q == PH_WRITE) && (idx_q == xrrg_pkg::LAST_SLOT);

endmodule

FILE: design/xorshift_ring_random_generator_core.sv
// Top level of the xorshift ring random generator with its register port.
// Generate: read both ring slots at acceptance, mix the registered data, write back
//   and load the result when the output frees; one generate per cycle while it drains.
// Seed: seed word, then 63 words from the shared 32x32 multiplier; no result.
// Reset: ring reads as all zeros until the first seed, position 0, out_bits 64.
// The output register lets a new request in while a result still waits.
module xorshift_ring_random_generator_core (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic [63:0] seed_value,
	// result channel
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] random_word,
	// register port
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [xrrg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_GEN  = 3'b010,
		ST_SEED = 3'b100
	} ctl_state_t;

	ctl_state_t state_q, state_d;
	logic [xrrg_pkg::POS_W-1:0] pos_q;
	logic [xrrg_pkg::OUT_BITS_W-1:0] out_bits_q;
	logic ring_valid_q;
	logic out_valid_q;
	logic [xrrg_pkg::WORD_W-1:0] random_word_q;

	logic accept, accept_gen, accept_seed, out_free, gen_commit, seed_done;
	logic [xrrg_pkg::POS_W-1:0] raddr_a, raddr_b;
	logic [xrrg_pkg::WORD_W-1:0] rdata_a, rdata_b, t_word, v_word, new_word, mix_result;
	xrrg_pkg::ring_wr_t seed_wr, ring_wr;

	// register port: single register, always ready
	assign pready = 1'b1;
	assign prdata = (paddr[2] == xrrg_pkg::REG_OUT_BITS) ? 32'(out_bits_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_bits_q <= xrrg_pkg::OUT_BITS_RESET;
		end else if (psel && penable && pwrite && paddr[2] == xrrg_pkg::REG_OUT_BITS) begin
			out_bits_q <= pwdata[xrrg_pkg::OUT_BITS_W-1:0];
		end
	end

	// output register frees up when empty or being drained
	assign out_free = !out_valid_q || out_ready;
	// commit a generate once its read data is back and the result has a place to go
	assign gen_commit = (state_q == ST_GEN) && out_free;

	// a new request enters when idle or in the same cycle a generate commits;
	// the next generate reads slots pos+1 and pos+12, never the slot being written
	assign in_ready = (state_q == ST_IDLE) || gen_commit;
	assign accept = in_valid && in_ready;
	assign accept_gen = accept && (req_type == xrrg_pkg::REQ_GENERATE);
	assign accept_seed = accept && (req_type == xrrg_pkg::REQ_SEED);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept_gen) state_d = ST_GEN;
				else if (accept_seed) state_d = ST_SEED;
			end
			ST_GEN: begin
				if (accept_gen) state_d = ST_GEN;
				else if (accept_seed) state_d = ST_SEED;
				else if (gen_commit) state_d = ST_IDLE;
			end
			ST_SEED: begin
				if (seed_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			ring_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept_gen) pos_q <= pos_q + xrrg_pkg::POS_STEP;
			// memory holds garbage until the first seed fills every slot
			if (accept_seed) ring_valid_q <= 1'b1;
		end
	end

	// read the new slot and the lagged slot at acceptance
	assign raddr_a = pos_q + xrrg_pkg::POS_STEP;
	assign raddr_b = pos_q + xrrg_pkg::POS_STEP + xrrg_pkg::LAG_AHEAD;

	// write port: generate write-back, else the seed sequencer
	always_comb begin
		if (gen_commit) begin
			ring_wr.we = 1'b1;
			ring_wr.addr = pos_q;
			ring_wr.data = new_word;
		end else begin
			ring_wr = seed_wr;
		end
	end

	xrrg_ring_mem u_ring (
		.clk(clk),
		.wr(ring_wr),
		.re(accept_gen),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	xrrg_seed_unit u_seed (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept_seed),
		.seed_value(seed_value),
		.wr(seed_wr),
		.done(seed_done)
	);

	assign t_word = ring_valid_q ? rdata_a : '0;
	assign v_word = ring_valid_q ? rdata_b : '0;

	xrrg_mix u_mix (
		.t_word(t_word),
		.v_word(v_word),
		.out_bits(out_bits_q),
		.new_word(new_word),
		.result(mix_result)
	);

	// result register: load on commit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (gen_commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (gen_commit) random_word_q <= mix_result;
	end

	assign out_valid = out_valid_q;
	assign random_word = random_word_q;

	// a committed generate always shows up as a result
	a_commit_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		gen_commit |=> out_valid)
		else $error("generate commit lost its result");

	// the seed sequencer only writes while seeding
	a_seed_write_in_seed: assert property (@(posedge clk) disable iff (!arst_n)
		seed_wr.we |-> state_q == ST_SEED)
		else $error("seed write outside seeding");

	// a seed taken while idle produces no result
	a_seed_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept_seed && state_q == ST_IDLE && !out_valid_q) |=> !out_valid_q)
		else $error("seed request produced a result");

	// position moves only on an accepted generate
	a_pos_moves_on_gen: assert property (@(posedge clk) disable iff (!arst_n)
		!accept_gen |=> $stable(pos_q))
		else $error("ring position moved without a generate");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the xorshift ring random generator core: directed table, then random phases.
module tb_top;

	// Settle longer than a seed walk, which shows no result.
	localparam int SETTLE_CYCLES = 400;
	localparam int HOLD_OFF_CYCLES = 200;
	// Quiet cycles allowed with no request or result moving.
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_ITEMS = 140;
	localparam int NUM_PHASES = 7;
	localparam int NUM_ROWS = 24;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [63:0] seed_value;
	logic out_valid;
	logic out_ready;
	logic [63:0] random_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [xrrg_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	xorshift_ring_random_generator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_word(random_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Shadow copy of the generator state, advanced at each accepted request.
	logic [63:0] ring_shadow [xrrg_pkg::RING_DEPTH];
	logic [xrrg_pkg::POS_W-1:0] pos_shadow;
	logic [xrrg_pkg::OUT_BITS_W-1:0] out_bits_shadow;

	// Words still owed by the block, oldest first.
	logic [63:0] pending_words [$];

	int mismatches = 0;
	bit idle_on = 1'b1;
	bit hold_off_req = 1'b0;

	// Directed table: request kind, seed word, whether the word is typed in, typed word.
	typedef struct packed {
		logic kind;
		logic [63:0] seed;
		logic typed;
		logic [63:0] word;
	} directed_row_t;

	directed_row_t directed_rows [NUM_ROWS] = '{
		// unseeded ring after reset gives zero words; seed field is ignored
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b1, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, ALL_ONES, 1'b1, 64'd0},
		// a zero seed refills the ring with zeros
		'{xrrg_pkg::REQ_SEED, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b1, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, ALL_ONES, 1'b1, 64'd0},
		'{xrrg_pkg::REQ_SEED, ALL_ONES, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, ALL_ONES, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_SEED, 64'h8000_0000_0000_0001, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, ALL_ONES, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_SEED, 64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		// back-to-back seeds: the second one wins
		'{xrrg_pkg::REQ_SEED, 64'd1, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_SEED, 64'hFEDC_BA98_7654_3210, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0},
		'{xrrg_pkg::REQ_GENERATE, 64'd0, 1'b0, 64'd0}
	};

	// Refill the shadow ring from a seed word; position stays where it is.
	function automatic void ring_fill(input logic [63:0] seed);
		logic [63:0] prev;
		ring_shadow[0] = seed;
		for (int i = 1; i < xrrg_pkg::RING_DEPTH; i++) begin
			prev = ring_shadow[i-1];
			ring_shadow[i] = xrrg_pkg::SEED_MULT * (prev ^ (prev >> 62)) + seed;
		end
	endfunction

	// Advance the ring one step and return the word the block should emit.
	function automatic logic [63:0] ring_next_word();
		logic [63:0] t;
		logic [63:0] v;
		logic [63:0] flipped;
		logic [63:0] keep;
		logic [xrrg_pkg::POS_W-1:0] ahead;
		pos_shadow = pos_shadow + xrrg_pkg::POS_STEP;
		ahead = pos_shadow + xrrg_pkg::LAG_AHEAD;
		t = ring_shadow[pos_shadow];
		v = ring_shadow[ahead];
		t = t ^ (t << 33);
		t = t ^ (t >> 26);
		v = v ^ (v << 27);
		v = v ^ (v >> 29);
		v = v ^ t;
		ring_shadow[pos_shadow] = v;
		for (int i = 0; i < xrrg_pkg::WORD_W; i++)
			flipped[i] = v[xrrg_pkg::WORD_W-1-i];
		// zero width keeps nothing, anything past 64 keeps everything
		if (out_bits_shadow == 0)
			keep = 64'd0;
		else if (out_bits_shadow >= 7'd64)
			keep = ALL_ONES;
		else
			keep = ALL_ONES << (7'd64 - out_bits_shadow);
		return flipped & keep;
	endfunction

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		mismatches++;
	endtask

	// Hold until every owed word has come back; always let at least one edge pass.
	task automatic wait_drain();
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	// Offer one request and return at the edge where it is taken.
	// The caller is at a rising edge; valid stays high into the next call when no gap is drawn.
	task automatic send_request(input logic kind, input logic [63:0] seed, input logic typed,
			input logic [63:0] typed_word);
		int gap;
		logic [63:0] word;
		if (idle_on && $urandom_range(99) < 18) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
		if (kind == xrrg_pkg::REQ_SEED) begin
			ring_fill(seed);
		end else begin
			word = ring_next_word();
			pending_words.push_back(typed ? typed_word : word);
		end
	endtask

	// Write out_bits once the block is idle; the upper data bits carry noise.
	task automatic write_out_bits(input logic [xrrg_pkg::OUT_BITS_W-1:0] bits);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= xrrg_pkg::PADDR_W'(4 * xrrg_pkg::REG_OUT_BITS);
		pwdata <= {25'($urandom), bits};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		out_bits_shadow = bits;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic logic [63:0] pick_seed();
		case ($urandom_range(9))
			0: return 64'd0;
			1: return ALL_ONES;
			2: return 64'd1 << $urandom_range(63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Result side: random stalls, plus one long hold-off counted here on request.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
			end else begin
				out_ready <= !idle_on || ($urandom_range(99) >= 18);
			end
		end
	end

	// Compare each word taken with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0)
				report_mismatch($sformatf("unexpected random_word %h", random_word));
			else if (random_word !== pending_words[0])
				report_mismatch($sformatf("random_word %h, want %h", random_word,
					pending_words[0]));
			if (pending_words.size() != 0)
				void'(pending_words.pop_front());
		end
	end

	// Drop the run if nothing moves for too long.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	logic [xrrg_pkg::OUT_BITS_W-1:0] phase_bits [NUM_PHASES];

	initial begin
		logic kind;
		logic [63:0] seed;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		req_type <= xrrg_pkg::REQ_GENERATE;
		seed_value <= 64'd0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= 32'd0;
		for (int i = 0; i < xrrg_pkg::RING_DEPTH; i++)
			ring_shadow[i] = 64'd0;
		pos_shadow = '0;
		out_bits_shadow = xrrg_pkg::OUT_BITS_RESET;
		// zero and past-64 widths are the special cases; end on a random width
		phase_bits = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64, 7'd33,
			xrrg_pkg::OUT_BITS_W'($urandom_range(2, 63))};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset width.
		for (int r = 0; r < NUM_ROWS; r++)
			send_request(directed_rows[r].kind, directed_rows[r].seed,
				directed_rows[r].typed, directed_rows[r].word);
		in_valid <= 1'b0;

		// Random phases, one width each.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			write_out_bits(phase_bits[ph]);
			// phase 2 runs with no idling on either side
			idle_on = (ph != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// stall results long enough for the block to back up its input
				if (ph == 3 && n == 20)
					hold_off_req = 1'b1;
				// pause requests until every owed word is back
				if (ph == 4 && n == 70) begin
					in_valid <= 1'b0;
					wait_drain();
				end
				kind = ($urandom_range(99) < 4) ? xrrg_pkg::REQ_SEED : xrrg_pkg::REQ_GENERATE;
				seed = (kind == xrrg_pkg::REQ_SEED) ? pick_seed() : {$urandom, $urandom};
				send_request(kind, seed, 1'b0, 64'd0);
			end
			in_valid <= 1'b0;
		end
		idle_on = 1'b1;

		// Drain, then give a trailing seed walk time to show any stray result.
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch($sformatf("%0d words never came", pending_words.size()));
		if (mismatches == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: sim.f
design/xrrg_pkg.sv
design/xrrg_ring_mem.sv
design/xrrg_mix.sv
design/xrrg_seed_unit.sv
design/xorshift_ring_random_generator_core.sv
bench/tb_top.sv
